FILE: rtl/core/kmp_pkg.sv
// Shared constants, codes, result type and helpers for the KMP first-match search core.
// No dependencies.
package kmp_pkg;

	localparam int              PATTERN_MAX = 128;
	localparam longint unsigned TEXT_MAX    = 65536;

	localparam int ACT_W    = 2;
	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 16;

	localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
	localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
	localparam int TPOS_W = $clog2(TEXT_MAX + 1);
	localparam int SUM_W  = TPOS_W + LEN_W + POS_W;

	localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PATTERN = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TEXT    = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_TAKEN    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_IGNORED  = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_NO_MATCH = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_MATCH    = 3'd4;
	localparam logic [STATUS_W-1:0] STAT_ALREADY  = 3'd5;
	localparam logic [STATUS_W-1:0] STAT_TOO_LONG = 3'd6;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    match_pos;
	} res_t;

	// start of the occurrence that ends at text byte tpos
	function automatic logic [POS_W-1:0] found_start(input logic [TPOS_W-1:0] tpos,
		input logic [LEN_W-1:0] len);
		logic [SUM_W-1:0] s;
		s = SUM_W'(tpos) + SUM_W'(1) - SUM_W'(len);
		return s[POS_W-1:0];
	endfunction

endpackage

FILE: rtl/core/kmp_in_if.sv
// Input channel: valid/ready handshake carrying action and char_value.
// Depends on kmp_pkg.
interface kmp_in_if import kmp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [CHAR_W-1:0] char_value;

	modport source (output valid, output action, output char_value, input ready);
	modport sink (input valid, input action, input char_value, output ready);
endinterface

FILE: rtl/core/kmp_out_if.sv
// Result channel: valid/ready handshake carrying status and match_pos.
// Depends on kmp_pkg.
interface kmp_out_if import kmp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [POS_W-1:0]    match_pos;

	modport source (output valid, output status, output match_pos, input ready);
	modport sink (input valid, input status, input match_pos, output ready);
endinterface

FILE: rtl/core/kmp_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kmp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/kmp_engine.sv
// Search sequencer: pattern and failure-table RAMs, online table build and KMP text scan.
// Depends on kmp_pkg, kmp_in_if and kmp_ram.
module kmp_engine import kmp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	kmp_in_if.sink    item,
	output logic      res_valid,
	output res_t      res,
	input  logic      res_ready
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]        state_q;
	logic [ACT_W-1:0]  act_q;
	logic [CHAR_W-1:0] char_q;
	logic [IDX_W-1:0]  m_q;
	logic [LEN_W-1:0]  pat_len_q;
	logic [IDX_W-1:0]  prefix_q;
	logic [IDX_W-1:0]  match_q;
	logic [TPOS_W-1:0] text_pos_q;
	logic              found_q;
	logic [POS_W-1:0]  found_pos_q;
	res_t              res_q;

	logic              take;
	logic [CHAR_W-1:0] pat_rdata;
	logic [IDX_W-1:0]  fail_rdata;
	logic [IDX_W-1:0]  pat_raddr;
	logic [IDX_W-1:0]  fail_raddr;
	logic              first_byte;
	logic              eval_hit;
	logic              eval_done;
	logic [LEN_W-1:0]  eval_len;
	logic              wr_en;
	logic [POS_W-1:0]  new_pos;

	assign item.ready = (state_q == S_IDLE);
	assign take       = item.valid && item.ready;
	assign res_valid  = (state_q == S_DONE);
	assign res        = res_q;

	assign first_byte = (act_q == ACT_PATTERN) && (pat_len_q == '0);
	assign eval_hit   = (pat_rdata == char_q);
	assign eval_done  = first_byte || eval_hit || (m_q == '0);
	assign eval_len   = first_byte ? '0 :
		(eval_hit ? LEN_W'(m_q) + LEN_W'(1) : '0);
	assign wr_en      = (state_q == S_EVAL) && eval_done && (act_q == ACT_PATTERN);
	assign new_pos    = found_start(text_pos_q, pat_len_q);

	// fallback: next probe address comes straight from the failure-table read
	always_comb begin
		if (state_q == S_EVAL) begin
			pat_raddr = fail_rdata;
		end else if (item.action == ACT_PATTERN) begin
			pat_raddr = prefix_q;
		end else begin
			pat_raddr = match_q;
		end
		fail_raddr = pat_raddr - IDX_W'(1);
	end

	kmp_ram #(.WIDTH(CHAR_W), .DEPTH(PATTERN_MAX)) u_pat_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pat_len_q[IDX_W-1:0]),
		.wdata (char_q),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	kmp_ram #(.WIDTH(IDX_W), .DEPTH(PATTERN_MAX)) u_fail_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pat_len_q[IDX_W-1:0]),
		.wdata (eval_len[IDX_W-1:0]),
		.raddr (fail_raddr),
		.rdata (fail_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_CLEAR;
			char_q      <= '0;
			m_q         <= '0;
			pat_len_q   <= '0;
			prefix_q    <= '0;
			match_q     <= '0;
			text_pos_q  <= '0;
			found_q     <= 1'b0;
			found_pos_q <= '0;
			res_q       <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						act_q  <= item.action;
						char_q <= item.char_value;
						m_q    <= pat_raddr;
						state_q <= S_DONE;
						case (item.action)
							ACT_CLEAR: begin
								pat_len_q   <= '0;
								prefix_q    <= '0;
								match_q     <= '0;
								text_pos_q  <= '0;
								found_q     <= 1'b0;
								found_pos_q <= '0;
								res_q       <= '{STAT_CLEARED, '0};
							end
							ACT_PATTERN: begin
								if (pat_len_q >= LEN_W'(PATTERN_MAX) || text_pos_q != '0
									|| found_q) begin
									res_q <= '{STAT_IGNORED, '0};
								end else begin
									state_q <= S_EVAL;
								end
							end
							ACT_TEXT: begin
								if (found_q) begin
									res_q <= '{STAT_ALREADY, found_pos_q};
								end else if (text_pos_q >= TPOS_W'(TEXT_MAX)) begin
									res_q <= '{STAT_TOO_LONG, '0};
								end else if (pat_len_q == '0) begin
									found_q     <= 1'b1;
									found_pos_q <= '0;
									text_pos_q  <= text_pos_q + TPOS_W'(1);
									res_q       <= '{STAT_MATCH, '0};
								end else begin
									state_q <= S_EVAL;
								end
							end
							default: begin
								if (found_q) begin
									res_q <= '{STAT_ALREADY, found_pos_q};
								end else begin
									res_q <= '{STAT_NO_MATCH, '0};
								end
							end
						endcase
					end
				end
				S_EVAL: begin
					if (!eval_done) begin
						m_q <= fail_rdata;
					end else begin
						state_q <= S_DONE;
						if (act_q == ACT_PATTERN) begin
							prefix_q  <= eval_len[IDX_W-1:0];
							pat_len_q <= pat_len_q + LEN_W'(1);
							res_q     <= '{STAT_TAKEN, '0};
						end else begin
							text_pos_q <= text_pos_q + TPOS_W'(1);
							if (eval_len >= pat_len_q) begin
								found_q     <= 1'b1;
								found_pos_q <= new_pos;
								match_q     <= '0;
								res_q       <= '{STAT_MATCH, new_pos};
							end else begin
								match_q <= eval_len[IDX_W-1:0];
								res_q   <= '{STAT_NO_MATCH, '0};
							end
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_wr_only_eval: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_EVAL))
		else $error("table write outside evaluation");

	a_match_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(pat_len_q != '0) |-> (LEN_W'(match_q) < pat_len_q))
		else $error("matched length reached pattern length");

	a_prefix_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(pat_len_q != '0) |-> (LEN_W'(prefix_q) < pat_len_q))
		else $error("prefix length reached pattern length");

	a_take_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q != S_IDLE))
		else $error("accepted transfer not processed");

	a_text_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		text_pos_q <= TPOS_W'(TEXT_MAX))
		else $error("text position beyond limit");
endmodule

FILE: rtl/core/kmp_first_match_search_core.sv
// KMP first-match search core: top level with result output register.
// Depends on kmp_pkg, kmp_in_if, kmp_out_if and kmp_engine.
//
// Usage: the item channel carries action (clear, pattern byte, text byte) and
// char_value; every accepted transfer yields exactly one result transfer with
// status and match_pos, in order. Send a clear, then the pattern bytes, then
// text bytes; the failure table is built as pattern bytes arrive.
// Sequence: clear, ignored and settled items go from acceptance to the done
// state, then to a result in the output register. Pattern and text bytes that
// probe the tables pass through the evaluation state, which repeats for each
// failure-table fallback step; each step is one read of the pattern and
// failure RAMs. Over a text, fallbacks are bounded by the bytes scanned.
// One item is in the engine at a time; a new item is accepted while the output
// register still holds the previous result.
// Reset clears all search state; the RAMs are not cleared, as only entries
// below the pattern length are ever read. When the receiver stalls, the output
// register holds its result, the engine holds the next one, and the item
// channel deasserts ready.
module kmp_first_match_search_core import kmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kmp_in_if.sink     item,
	kmp_out_if.source  result
);
	logic res_valid;
	res_t res;
	logic res_ready;
	logic out_valid_q;
	res_t out_q;

	kmp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	assign res_ready = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.status    = out_q.status;
	assign result.match_pos = out_q.match_pos;
endmodule
